// File: hw/rtl/perfect_reflector_white_balance_core_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the perfect reflector white balance core.
// Each macro checks a property on the rising clock edge, held off during reset.
// ----------------------------------------------------------------------------
`ifndef PERFECT_REFLECTOR_WHITE_BALANCE_CORE_DEFINES_SVH
`define PERFECT_REFLECTOR_WHITE_BALANCE_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PRWB_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PRWB_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hw/rtl/prwb_pkg.sv
// ----------------------------------------------------------------------------
// prwb_pkg
// Shared constants and types of the perfect reflector white balance core.
// ----------------------------------------------------------------------------
`default_nettype none

package prwb_pkg;

   localparam int BinW    = 10;
   localparam int CountW  = 20;
   localparam int SumW    = 28;
   localparam int RunW    = 30;
   localparam int TargetW = 36;
   localparam int RatioW  = 16;

   localparam logic [BinW-1:0]   TopBin     = 10'd765;
   localparam logic [CountW-1:0] CountMax   = 20'd1048575;
   localparam logic [SumW-1:0]   SumMax     = 28'hFFFFFFF;
   localparam logic [RatioW-1:0] RatioReset = 16'd3277;

   localparam logic [1:0] OpHist    = 2'd0;
   localparam logic [1:0] OpMean    = 2'd1;
   localparam logic [1:0] OpCorrect = 2'd2;

   // Commands from the sequencer to the histogram unit.
   typedef struct packed {
      logic                 inc;
      logic                 walk;
      logic [BinW-1:0]      bin;
      logic [TargetW-1:0]   target;
   } hist_cmd_type;

   typedef struct packed {
      logic                 busy;
      logic [BinW-1:0]      threshold;
   } hist_stat_type;

endpackage

`default_nettype wire

// File: hw/rtl/perfect_reflector_white_balance_core.sv
// ----------------------------------------------------------------------------
// perfect_reflector_white_balance_core
// Three-pass perfect reflector white balance: histogram, mean and correction.
// ----------------------------------------------------------------------------
// After reset the core sweeps its 766-bin histogram to zero with req_stall high.
// The last word of the histogram pass starts a walk over every bin. The last
// word of the mean pass runs three divisions on the shared divider, or sets the
// means to zero when no pixel was bright. A correction word is accepted, then
// per channel is multiplied, issued to the divider and divided, or passed
// through when its mean is zero; then the result register is loaded. The
// shared divider sets the correction rate.
`default_nettype none

module perfect_reflector_white_balance_core (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_write_enable,
   input  wire logic [15:0] csr_write_data,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_operation,
   input  wire logic [7:0]  req_red_in,
   input  wire logic [7:0]  req_green_in,
   input  wire logic [7:0]  req_blue_in,
   input  wire logic        req_pass_end,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [7:0]       rsp_red_out,
   output logic [7:0]       rsp_green_out,
   output logic [7:0]       rsp_blue_out,
   output logic             rsp_degenerate,
   output logic             rsp_frame_end
);
   import prwb_pkg::*;

`include "perfect_reflector_white_balance_core_defines.svh"

   typedef enum logic [8:0] {
      ST_IDLE  = 9'b000000001,
      ST_WALK  = 9'b000000010,
      ST_HWAIT = 9'b000000100,
      ST_MEAN  = 9'b000001000,
      ST_MWAIT = 9'b000010000,
      ST_MUL   = 9'b000100000,
      ST_CDIV  = 9'b001000000,
      ST_CWAIT = 9'b010000000,
      ST_PUSH  = 9'b100000000
   } core_state_type;

   core_state_type      state_ff, state_in;
   logic [RatioW-1:0]   ratio_ff, ratio_in;
   logic [CountW-1:0]   pix_cnt_ff, pix_cnt_in;
   logic [7:0]          peak_ff, peak_in;
   logic [CountW-1:0]   bcount_ff, bcount_in;
   logic [SumW-1:0]     sum_ff [3];
   logic [SumW-1:0]     sum_in [3];
   logic [7:0]          mean_ff [3];
   logic [7:0]          mean_in [3];
   logic [7:0]          ch_ff [3];
   logic [7:0]          ch_in [3];
   logic [7:0]          res_ff [3];
   logic [7:0]          res_in [3];
   logic                last_ff, last_in;
   logic [1:0]          idx_ff, idx_in;
   logic [15:0]         prod_ff, prod_in;
   logic                deg_ff, deg_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [7:0]          rsp_ch_ff [3];
   logic [7:0]          rsp_ch_in [3];
   logic                rsp_deg_ff, rsp_deg_in;
   logic                rsp_end_ff, rsp_end_in;

   logic                accept;
   logic                push_go;
   logic [BinW-1:0]     total;
   logic [7:0]          req_ch [3];
   logic [SumW:0]       sum_add [3];
   logic                div_start;
   logic [SumW-1:0]     div_dividend;
   logic [CountW-1:0]   div_divisor;
   logic                div_busy;
   logic                div_done;
   logic [7:0]          div_q;
   hist_cmd_type        hcmd;
   hist_stat_type       hstat;

   assign req_ch[0] = req_red_in;
   assign req_ch[1] = req_green_in;
   assign req_ch[2] = req_blue_in;
   assign total     = {2'b00, req_red_in} + {2'b00, req_green_in} + {2'b00, req_blue_in};
   assign req_stall = !((state_ff == ST_IDLE) && !hstat.busy);
   assign accept    = req_valid && !req_stall;
   assign push_go   = (state_ff == ST_PUSH) && !(rsp_valid_ff && rsp_stall);

   always_comb begin
      state_in     = state_ff;
      ratio_in     = csr_write_enable ? csr_write_data : ratio_ff;
      pix_cnt_in   = pix_cnt_ff;
      peak_in      = peak_ff;
      bcount_in    = bcount_ff;
      last_in      = last_ff;
      idx_in       = idx_ff;
      prod_in      = prod_ff;
      deg_in       = deg_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_deg_in   = rsp_deg_ff;
      rsp_end_in   = rsp_end_ff;
      div_start    = 1'b0;
      div_dividend = sum_ff[idx_ff];
      div_divisor  = bcount_ff;
      hcmd.inc     = 1'b0;
      hcmd.walk    = 1'b0;
      hcmd.bin     = total;
      hcmd.target  = {20'd0, ratio_ff} * {16'd0, pix_cnt_ff};
      for (int k = 0; k < 3; k++) begin
         sum_in[k]    = sum_ff[k];
         mean_in[k]   = mean_ff[k];
         ch_in[k]     = ch_ff[k];
         res_in[k]    = res_ff[k];
         rsp_ch_in[k] = rsp_ch_ff[k];
         sum_add[k]   = {1'b0, sum_ff[k]} + {21'd0, req_ch[k]};
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               last_in = req_pass_end;
               idx_in  = 2'd0;
               deg_in  = 1'b0;
               for (int k = 0; k < 3; k++) begin
                  ch_in[k] = req_ch[k];
               end
               case (req_operation)
                  OpHist: begin
                     hcmd.inc   = 1'b1;
                     pix_cnt_in = (pix_cnt_ff >= CountMax) ? CountMax : pix_cnt_ff + 20'd1;
                     for (int k = 0; k < 3; k++) begin
                        if (req_ch[k] > peak_in) begin
                           peak_in = req_ch[k];
                        end
                     end
                     if (req_pass_end) begin
                        state_in = ST_WALK;
                     end
                  end
                  OpMean: begin
                     if (total > hstat.threshold) begin
                        bcount_in = (bcount_ff >= CountMax) ? CountMax : bcount_ff + 20'd1;
                        for (int k = 0; k < 3; k++) begin
                           sum_in[k] = sum_add[k][SumW] ? SumMax : sum_add[k][SumW-1:0];
                        end
                     end
                     if (req_pass_end) begin
                        state_in = ST_MEAN;
                     end
                  end
                  OpCorrect: begin
                     state_in = ST_MUL;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_WALK: begin
            // The target is taken from the final pixel count, then counts clear.
            if (!hstat.busy) begin
               hcmd.walk  = 1'b1;
               pix_cnt_in = '0;
               bcount_in  = '0;
               for (int k = 0; k < 3; k++) begin
                  sum_in[k] = '0;
               end
               state_in = ST_HWAIT;
            end
         end
         ST_HWAIT: begin
            if (!hstat.busy) begin
               state_in = ST_IDLE;
            end
         end
         ST_MEAN: begin
            if (bcount_ff == '0) begin
               for (int k = 0; k < 3; k++) begin
                  mean_in[k] = 8'd0;
               end
               state_in = ST_IDLE;
            end else begin
               div_start = 1'b1;
               state_in  = ST_MWAIT;
            end
         end
         ST_MWAIT: begin
            if (div_done) begin
               mean_in[idx_ff] = div_q;
               if (idx_ff == 2'd2) begin
                  idx_in    = 2'd0;
                  bcount_in = '0;
                  for (int k = 0; k < 3; k++) begin
                     sum_in[k] = '0;
                  end
                  state_in = ST_IDLE;
               end else begin
                  idx_in   = idx_ff + 2'd1;
                  state_in = ST_MEAN;
               end
            end
         end
         ST_MUL: begin
            prod_in  = {8'd0, ch_ff[idx_ff]} * {8'd0, peak_ff};
            state_in = ST_CDIV;
         end
         ST_CDIV: begin
            div_dividend = {12'd0, prod_ff};
            div_divisor  = {12'd0, mean_ff[idx_ff]};
            if (mean_ff[idx_ff] == 8'd0) begin
               res_in[idx_ff] = ch_ff[idx_ff];
               deg_in         = 1'b1;
               if (idx_ff == 2'd2) begin
                  idx_in   = 2'd0;
                  state_in = ST_PUSH;
               end else begin
                  idx_in   = idx_ff + 2'd1;
                  state_in = ST_MUL;
               end
            end else begin
               div_start = 1'b1;
               state_in  = ST_CWAIT;
            end
         end
         ST_CWAIT: begin
            if (div_done) begin
               res_in[idx_ff] = div_q;
               if (idx_ff == 2'd2) begin
                  idx_in   = 2'd0;
                  state_in = ST_PUSH;
               end else begin
                  idx_in   = idx_ff + 2'd1;
                  state_in = ST_MUL;
               end
            end
         end
         ST_PUSH: begin
            if (!(rsp_valid_ff && rsp_stall)) begin
               rsp_valid_in = 1'b1;
               for (int k = 0; k < 3; k++) begin
                  rsp_ch_in[k] = res_ff[k];
               end
               rsp_deg_in = deg_ff;
               rsp_end_in = last_ff;
               if (last_ff) begin
                  peak_in = 8'd0;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ratio_ff     <= RatioReset;
         pix_cnt_ff   <= '0;
         peak_ff      <= '0;
         bcount_ff    <= '0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         for (int k = 0; k < 3; k++) begin
            sum_ff[k]  <= '0;
            mean_ff[k] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         ratio_ff     <= ratio_in;
         pix_cnt_ff   <= pix_cnt_in;
         peak_ff      <= peak_in;
         bcount_ff    <= bcount_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
         for (int k = 0; k < 3; k++) begin
            sum_ff[k]  <= sum_in[k];
            mean_ff[k] <= mean_in[k];
         end
      end
      last_ff    <= last_in;
      prod_ff    <= prod_in;
      deg_ff     <= deg_in;
      rsp_deg_ff <= rsp_deg_in;
      rsp_end_ff <= rsp_end_in;
      for (int k = 0; k < 3; k++) begin
         ch_ff[k]     <= ch_in[k];
         res_ff[k]    <= res_in[k];
         rsp_ch_ff[k] <= rsp_ch_in[k];
      end
   end

   prwb_hist u_hist (
      .clock (clock),
      .reset (reset),
      .cmd   (hcmd),
      .stat  (hstat)
   );

   prwb_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .busy     (div_busy),
      .done     (div_done),
      .quotient (div_q)
   );

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_red_out    = rsp_ch_ff[0];
   assign rsp_green_out  = rsp_ch_ff[1];
   assign rsp_blue_out   = rsp_ch_ff[2];
   assign rsp_degenerate = rsp_deg_ff;
   assign rsp_frame_end  = rsp_end_ff;

   `PRWB_ASSERT_NOW(a_div_start_idle, div_start, !div_busy, "divider started while busy")
   `PRWB_ASSERT_NOW(a_walk_start_idle, hcmd.walk, !hstat.busy, "walk started while busy")
   `PRWB_ASSERT_NOW(a_idx_range, 1'b1, idx_ff != 2'd3, "channel index out of range")
   `PRWB_ASSERT_NEXT(a_push_loads, push_go, rsp_valid_ff && (state_ff == ST_IDLE), "no load")

endmodule

`default_nettype wire

// File: hw/rtl/prwb_div.sv
// ----------------------------------------------------------------------------
// prwb_div
// Shared restoring divider with an 8-bit quotient that saturates at 255.
// ----------------------------------------------------------------------------
`default_nettype none

module prwb_div (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      start,
   input  wire logic [prwb_pkg::SumW-1:0]   dividend,
   input  wire logic [prwb_pkg::CountW-1:0] divisor,
   output logic                           busy,
   output logic                           done,
   output logic [7:0]                     quotient
);
   import prwb_pkg::*;

   logic                run_ff, run_in;
   logic                done_ff, done_in;
   logic [3:0]          step_ff, step_in;
   logic [SumW-1:0]     rem_ff, rem_in;
   logic [CountW-1:0]   dvs_ff, dvs_in;
   logic [7:0]          q_ff, q_in;
   logic [SumW-1:0]     trial;

   always_comb begin
      run_in  = run_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      q_in    = q_ff;
      trial   = {8'd0, dvs_ff} << step_ff[2:0];
      if (start) begin
         run_in  = 1'b1;
         step_in = 4'd8;
         rem_in  = dividend;
         dvs_in  = divisor;
         q_in    = 8'd0;
      end else if (run_ff) begin
         // The first step only checks whether the quotient reaches 256.
         if (step_ff[3]) begin
            if ({1'b0, rem_ff} >= {1'b0, dvs_ff, 8'd0}) begin
               q_in    = 8'd255;
               run_in  = 1'b0;
               done_in = 1'b1;
            end else begin
               step_in = 4'd7;
            end
         end else begin
            if (rem_ff >= trial) begin
               rem_in = rem_ff - trial;
               q_in[step_ff[2:0]] = 1'b1;
            end
            if (step_ff == 4'd0) begin
               run_in  = 1'b0;
               done_in = 1'b1;
            end else begin
               step_in = step_ff - 4'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      step_ff <= step_in;
      rem_ff  <= rem_in;
      dvs_ff  <= dvs_in;
      q_ff    <= q_in;
   end

   assign busy     = run_ff;
   assign done     = done_ff;
   assign quotient = q_ff;

endmodule

`default_nettype wire

// File: hw/rtl/prwb_hist.sv
// ----------------------------------------------------------------------------
// prwb_hist
// Histogram memory of pixel sums with increment, threshold walk and clearing.
// ----------------------------------------------------------------------------
`default_nettype none

module prwb_hist (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire prwb_pkg::hist_cmd_type  cmd,
   output prwb_pkg::hist_stat_type      stat
);
   import prwb_pkg::*;

   localparam int Bins = 766;

   typedef enum logic [4:0] {
      H_CLEAR = 5'b00001,
      H_IDLE  = 5'b00010,
      H_INC   = 5'b00100,
      H_WALK  = 5'b01000,
      H_DRAIN = 5'b10000
   } hist_state_type;

   logic [CountW-1:0] mem [Bins];

   hist_state_type      state_ff, state_in;
   logic [BinW-1:0]     addr_ff, addr_in;
   logic [BinW-1:0]     bin_ff, bin_in;
   logic [BinW-1:0]     prev_ff, prev_in;
   logic                vld_ff, vld_in;
   logic [RunW-1:0]     run_ff, run_in;
   logic                found_ff, found_in;
   logic [BinW-1:0]     thr_ff, thr_in;
   logic [TargetW-1:0]  target_ff, target_in;
   logic [CountW-1:0]   rd_data_ff;
   logic [BinW-1:0]     rd_addr;
   logic                wr_en;
   logic [BinW-1:0]     wr_addr;
   logic [CountW-1:0]   wr_data;
   logic [RunW-1:0]     run_sum;
   logic                hit;

   always_comb begin
      rd_addr = (state_ff == H_IDLE) ? cmd.bin : addr_ff;
      wr_en   = 1'b0;
      wr_addr = addr_ff;
      wr_data = '0;
      if (state_ff == H_CLEAR) begin
         wr_en = 1'b1;
      end else if (state_ff == H_INC) begin
         wr_en   = 1'b1;
         wr_addr = bin_ff;
         wr_data = (rd_data_ff >= CountMax) ? CountMax : rd_data_ff + 20'd1;
      end else if (vld_ff) begin
         // The walk empties each bin once its count has been taken.
         wr_en   = 1'b1;
         wr_addr = prev_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_comb begin
      state_in  = state_ff;
      addr_in   = addr_ff;
      bin_in    = bin_ff;
      prev_in   = prev_ff;
      vld_in    = 1'b0;
      run_in    = run_ff;
      found_in  = found_ff;
      thr_in    = thr_ff;
      target_in = target_ff;
      run_sum   = run_ff + {10'd0, rd_data_ff};
      hit       = {run_sum, 16'd0} >= {10'd0, target_ff};
      if (vld_ff) begin
         run_in = run_sum;
         if (!found_ff && hit) begin
            thr_in   = prev_ff;
            found_in = 1'b1;
         end
      end
      case (state_ff)
         H_CLEAR: begin
            if (addr_ff == '0) begin
               state_in = H_IDLE;
            end else begin
               addr_in = addr_ff - 10'd1;
            end
         end
         H_IDLE: begin
            if (cmd.inc) begin
               bin_in   = cmd.bin;
               state_in = H_INC;
            end else if (cmd.walk) begin
               target_in = cmd.target;
               run_in    = '0;
               found_in  = 1'b0;
               thr_in    = '0;
               addr_in   = TopBin;
               state_in  = H_WALK;
            end
         end
         H_INC: begin
            state_in = H_IDLE;
         end
         H_WALK: begin
            vld_in  = 1'b1;
            prev_in = addr_ff;
            if (addr_ff == '0) begin
               state_in = H_DRAIN;
            end else begin
               addr_in = addr_ff - 10'd1;
            end
         end
         H_DRAIN: begin
            state_in = H_IDLE;
         end
         default: begin
            state_in = H_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= H_CLEAR;
         addr_ff  <= TopBin;
         vld_ff   <= 1'b0;
         found_ff <= 1'b0;
         thr_ff   <= '0;
         run_ff   <= '0;
      end else begin
         state_ff <= state_in;
         addr_ff  <= addr_in;
         vld_ff   <= vld_in;
         found_ff <= found_in;
         thr_ff   <= thr_in;
         run_ff   <= run_in;
      end
      bin_ff    <= bin_in;
      prev_ff   <= prev_in;
      target_ff <= target_in;
   end

   assign stat.busy      = (state_ff != H_IDLE);
   assign stat.threshold = thr_ff;

endmodule

`default_nettype wire

// File: test/tb.sv
// ----------------------------------------------------------------------------
// White balance core testbench
// Streams frames three times (histogram, mean, correction) through the core,
// predicts every corrected pixel with a model of its own, and checks each
// result word as it leaves. Both sides idle at random, and the receiver once
// holds off long enough to back the core up.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
   import prwb_pkg::*;

   localparam logic [1:0] OpIgnored = 2'd3;
   localparam int         NumBins   = 766;
   localparam int         CycleLimit = 3000000;
   localparam int         SettleCycles = 1000;

   typedef struct {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic       degenerate;
      logic       frame_end;
   } wb_pixel_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_write_enable = 1'b0;
   logic [15:0] csr_write_data = '0;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_operation = OpHist;
   logic [7:0]  req_red_in = '0;
   logic [7:0]  req_green_in = '0;
   logic [7:0]  req_blue_in = '0;
   logic        req_pass_end = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [7:0]  rsp_red_out;
   logic [7:0]  rsp_green_out;
   logic [7:0]  rsp_blue_out;
   logic        rsp_degenerate;
   logic        rsp_frame_end;

   perfect_reflector_white_balance_core dut (
      .clock(clock), .reset(reset),
      .csr_write_enable(csr_write_enable), .csr_write_data(csr_write_data),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_operation(req_operation), .req_red_in(req_red_in),
      .req_green_in(req_green_in), .req_blue_in(req_blue_in),
      .req_pass_end(req_pass_end),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_red_out(rsp_red_out), .rsp_green_out(rsp_green_out),
      .rsp_blue_out(rsp_blue_out), .rsp_degenerate(rsp_degenerate),
      .rsp_frame_end(rsp_frame_end)
   );

   // Predicted state of the core.
   int unsigned bin_count [NumBins];
   int unsigned pixels_seen, peak, threshold, bright_n;
   int unsigned chan_sum [3];
   int unsigned chan_mean [3];
   logic [15:0] ratio;

   wb_pixel_type expected_pixels [$];
   int errors = 0;
   int words_sent = 0;
   int burst_left = 0;
   int gap_pct = 30;
   int stall_mode = 0;
   int stall_phase = 0;
   int hold_left = 0;
   bit hold_request = 0;
   int cycles = 0;

   // Frame content, reused by all three passes.
   logic [7:0] frame_red [$];
   logic [7:0] frame_green [$];
   logic [7:0] frame_blue [$];

   initial begin
      forever #1 clock = ~clock;
   end

   function automatic int unsigned sat_count(input int unsigned v);
      return (v >= {12'd0, CountMax}) ? {12'd0, CountMax} : v + 1;
   endfunction

   function automatic logic [7:0] corrected(input int unsigned c, input int unsigned mean,
                                            inout logic deg);
      int unsigned v;
      if (mean == 0) begin
         deg = 1'b1;
         return c[7:0];
      end
      v = (c * peak) / mean;
      return (v > 255) ? 8'd255 : v[7:0];
   endfunction

   task automatic clear_model();
      foreach (bin_count[i]) bin_count[i] = 0;
      pixels_seen = 0;
      peak = 0;
      threshold = 0;
      bright_n = 0;
      for (int k = 0; k < 3; k++) begin
         chan_sum[k] = 0;
         chan_mean[k] = 0;
      end
      ratio = RatioReset;
   endtask

   task automatic predict_word(input logic [1:0] op, input logic [7:0] r, input logic [7:0] g,
                               input logic [7:0] b, input logic last);
      int unsigned ch [3];
      int unsigned total, m, s;
      longint unsigned goal, run;
      wb_pixel_type px;
      logic deg;
      ch[0] = {24'd0, r};
      ch[1] = {24'd0, g};
      ch[2] = {24'd0, b};
      total = ch[0] + ch[1] + ch[2];
      case (op)
         OpHist: begin
            bin_count[total] = sat_count(bin_count[total]);
            pixels_seen = sat_count(pixels_seen);
            for (int k = 0; k < 3; k++) if (ch[k] > peak) peak = ch[k];
            if (last) begin
               // Walk down from the top bin until enough bright pixels are covered.
               goal = longint'(ratio) * pixels_seen;
               run = 0;
               threshold = 0;
               for (int i = NumBins - 1; i >= 0; i--) begin
                  run += bin_count[i];
                  if ((run << 16) >= goal) begin
                     threshold = i;
                     break;
                  end
               end
               foreach (bin_count[i]) bin_count[i] = 0;
               pixels_seen = 0;
               bright_n = 0;
               for (int k = 0; k < 3; k++) chan_sum[k] = 0;
            end
         end
         OpMean: begin
            if (total > threshold) begin
               bright_n = sat_count(bright_n);
               for (int k = 0; k < 3; k++) begin
                  s = chan_sum[k] + ch[k];
                  chan_sum[k] = (s > {4'd0, SumMax}) ? {4'd0, SumMax} : s;
               end
            end
            if (last) begin
               for (int k = 0; k < 3; k++) begin
                  m = (bright_n == 0) ? 0 : chan_sum[k] / bright_n;
                  chan_mean[k] = (m > 255) ? 255 : m;
                  chan_sum[k] = 0;
               end
               bright_n = 0;
            end
         end
         OpCorrect: begin
            deg = 1'b0;
            px.red = corrected(ch[0], chan_mean[0], deg);
            px.green = corrected(ch[1], chan_mean[1], deg);
            px.blue = corrected(ch[2], chan_mean[2], deg);
            px.degenerate = deg;
            px.frame_end = last;
            expected_pixels.push_back(px);
            if (last) peak = 0;
         end
         default: ;
      endcase
   endtask

   // Model update on every accepted word and register write.
   always @(posedge clock) begin
      if (reset) begin
         clear_model();
      end else begin
         if (csr_write_enable) ratio = csr_write_data;
         if (req_valid && !req_stall)
            predict_word(req_operation, req_red_in, req_green_in, req_blue_in, req_pass_end);
      end
   end

   // Result checker.
   always @(posedge clock) begin
      wb_pixel_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_pixels.size() == 0) begin
            $display("%0t: result word with nothing expected: %h %h %h deg %b end %b", $time,
                     rsp_red_out, rsp_green_out, rsp_blue_out, rsp_degenerate, rsp_frame_end);
            errors++;
         end else begin
            want = expected_pixels.pop_front();
            if (rsp_red_out !== want.red) begin
               $display("%0t: red expected %h actual %h", $time, want.red, rsp_red_out);
               errors++;
            end
            if (rsp_green_out !== want.green) begin
               $display("%0t: green expected %h actual %h", $time, want.green, rsp_green_out);
               errors++;
            end
            if (rsp_blue_out !== want.blue) begin
               $display("%0t: blue expected %h actual %h", $time, want.blue, rsp_blue_out);
               errors++;
            end
            if (rsp_degenerate !== want.degenerate) begin
               $display("%0t: degenerate expected %b actual %b", $time, want.degenerate,
                        rsp_degenerate);
               errors++;
            end
            if (rsp_frame_end !== want.frame_end) begin
               $display("%0t: frame_end expected %b actual %b", $time, want.frame_end,
                        rsp_frame_end);
               errors++;
            end
         end
      end
   end

   // Receiver stall pattern, with a long hold-off on request.
   always @(posedge clock) begin
      stall_phase++;
      if (hold_request) begin
         hold_left = 4000;
         hold_request = 0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         case (stall_mode)
            1: rsp_stall <= ($urandom_range(0, 3) == 0);
            2: rsp_stall <= ((stall_phase % 11) < 6);
            default: rsp_stall <= 1'b0;
         endcase
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CycleLimit) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   task automatic send_word(input logic [1:0] op, input logic [7:0] r, input logic [7:0] g,
                            input logic [7:0] b, input logic last);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         if ($urandom_range(0, 99) < gap_pct) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_operation <= op;
      req_red_in <= r;
      req_green_in <= g;
      req_blue_in <= b;
      req_pass_end <= last;
      forever begin
         @(posedge clock);
         if (!req_stall) break;
      end
      if (op != OpIgnored) words_sent++;
   endtask

   // Lets the core drain and finish any threshold walk before a register write.
   task automatic settle();
      req_valid <= 1'b0;
      while (expected_pixels.size() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic write_ratio(input logic [15:0] value);
      settle();
      csr_write_enable <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic run_pass(input logic [1:0] op, input bit noisy);
      for (int i = 0; i < frame_red.size(); i++) begin
         if (noisy && $urandom_range(0, 19) == 0)
            send_word(OpIgnored, 8'($urandom), 8'($urandom), 8'($urandom),
                      1'($urandom_range(0, 1)));
         send_word(op, frame_red[i], frame_green[i], frame_blue[i], i == frame_red.size() - 1);
      end
   endtask

   task automatic run_frame(input bit noisy);
      run_pass(OpHist, noisy);
      run_pass(OpMean, noisy);
      run_pass(OpCorrect, noisy);
   endtask

   task automatic add_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
      frame_red.push_back(r);
      frame_green.push_back(g);
      frame_blue.push_back(b);
   endtask

   task automatic fill_random_frame(input int count);
      int style;
      frame_red.delete();
      frame_green.delete();
      frame_blue.delete();
      style = $urandom_range(0, 3);
      for (int i = 0; i < count; i++) begin
         case (style)
            0: add_pixel(8'($urandom), 8'($urandom), 8'($urandom));
            1: add_pixel(8'($urandom_range(180, 255)), 8'($urandom_range(150, 255)),
                         8'($urandom_range(120, 255)));
            2: add_pixel(8'($urandom_range(0, 40)), 8'($urandom_range(0, 255)),
                         8'($urandom_range(0, 60)));
            default: add_pixel($urandom_range(0, 1) ? 8'd255 : 8'd0, 8'($urandom),
                               $urandom_range(0, 3) ? 8'($urandom) : 8'd0);
         endcase
      end
   endtask

   task automatic test_extremes();
      frame_red.delete();
      frame_green.delete();
      frame_blue.delete();
      add_pixel(8'd0, 8'd0, 8'd0);
      add_pixel(8'd255, 8'd255, 8'd255);
      add_pixel(8'd255, 8'd0, 8'd0);
      add_pixel(8'd0, 8'd255, 8'd128);
      add_pixel(8'd85, 8'd170, 8'd1);
      run_frame(0);
   endtask

   task automatic test_zero_channel_mean();
      // No pixel lies above the threshold, so every mean is zero and all channels pass through.
      frame_red.delete();
      frame_green.delete();
      frame_blue.delete();
      add_pixel(8'd0, 8'd255, 8'd250);
      add_pixel(8'd0, 8'd240, 8'd255);
      add_pixel(8'd200, 8'd10, 8'd5);
      run_frame(0);
   endtask

   task automatic test_ratio_extremes();
      // A zero ratio puts the threshold at the top bin, leaving no bright pixel at all.
      write_ratio(16'd0);
      test_extremes();
      write_ratio(16'hFFFF);
      test_extremes();
      write_ratio(RatioReset);
   endtask

   task automatic test_ignored_word();
      send_word(OpIgnored, 8'hFF, 8'hFF, 8'hFF, 1'b1);
      send_word(OpIgnored, 8'h00, 8'h00, 8'h00, 1'b0);
      send_word(OpCorrect, 8'h7F, 8'h80, 8'h01, 1'b1);
   endtask

   task automatic test_backpressure();
      settle();
      fill_random_frame(12);
      run_pass(OpHist, 0);
      run_pass(OpMean, 0);
      gap_pct = 0;
      hold_request = 1;
      run_pass(OpCorrect, 0);
      gap_pct = 30;
   endtask

   task automatic test_random_frames();
      int target_words;
      int pick;
      target_words = 1400;
      while (words_sent < target_words) begin
         pick = $urandom_range(0, 19);
         if (pick == 0) begin
            write_ratio($urandom_range(0, 3) == 0 ? 16'hFFFF : 16'($urandom));
            stall_mode = $urandom_range(0, 2);
            gap_pct = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(10, 70);
         end
         fill_random_frame($urandom_range(0, 7) == 0 ? $urandom_range(40, 80)
                                                     : $urandom_range(1, 16));
         if (pick == 1) begin
            // Broken sequence: passes out of order or repeated.
            run_pass(OpCorrect, 1);
            run_pass(OpMean, 1);
            run_pass(OpMean, 1);
            run_pass(OpCorrect, 1);
         end else begin
            run_frame(pick < 5);
         end
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_extremes();
      test_zero_channel_mean();
      test_ignored_word();
      test_ratio_extremes();
      stall_mode = 1;
      test_backpressure();
      stall_mode = 2;
      test_random_frames();
      req_valid <= 1'b0;
      while (expected_pixels.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (errors == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

`default_nettype wire
